/* hdl/reprojection_error_jacobian_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the reprojection error and Jacobian block
// Shared concurrent-assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef REPROJECTION_ERROR_JACOBIAN_DEFINES_SVH
`define REPROJECTION_ERROR_JACOBIAN_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define REJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled in reset
`define REJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

/* hdl/rej_pkg.sv */
// ---------------------------------------------------------------------------
// rej_pkg
// Types, constants and fixed-point helpers of the reprojection block.
// ---------------------------------------------------------------------------
`default_nettype none

package rej_pkg;

    localparam int DW    = 32;          // data width
    localparam int FB    = 16;          // fraction bits of Q values
    localparam int RF    = 30;          // fraction bits of rotation entries
    localparam int PW    = 2 * DW;      // full product width
    localparam int NW    = 2 * DW;      // divider numerator width
    localparam int NIW   = $clog2(NW);
    localparam int QB    = DW - 1;      // quotient bits below saturation
    localparam int DSTEP = 4;           // divider steps per stage
    localparam int DSTG  = (QB + DSTEP - 1) / DSTEP;
    localparam int NREG  = 8;
    localparam int RIW   = $clog2(NREG);
    localparam int CW    = 64;
    localparam int AW    = RIW + 3;

    typedef logic signed [DW-1:0] q_t;
    typedef logic signed [PW-1:0] prod_t;

    localparam q_t QMAX = {1'b0, {(DW-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(DW-1){1'b0}}};

    // register indexes
    localparam logic [RIW-1:0] REG_ROT_00_01      = RIW'(0);
    localparam logic [RIW-1:0] REG_ROT_02_10      = RIW'(1);
    localparam logic [RIW-1:0] REG_ROT_11_12      = RIW'(2);
    localparam logic [RIW-1:0] REG_ROT_20_21      = RIW'(3);
    localparam logic [RIW-1:0] REG_ROT_22_TRANS_X = RIW'(4);
    localparam logic [RIW-1:0] REG_TRANS_Y_Z      = RIW'(5);
    localparam logic [RIW-1:0] REG_FOCAL_XY       = RIW'(6);
    localparam logic [RIW-1:0] REG_CENTER_XY      = RIW'(7);

    localparam logic [CW-1:0] REG_RESET [NREG] = '{
        CW'(1073741824), CW'(0), CW'(1073741824), CW'(0),
        CW'(1073741824), CW'(0), CW'(0), CW'(0)
    };

    // decoded pose and camera
    typedef struct packed {
        logic [2:0][2:0][DW-1:0] r;
        logic [2:0][DW-1:0]      t;
        logic [DW-1:0]           fx;
        logic [DW-1:0]           fy;
        logic [DW-1:0]           cx;
        logic [DW-1:0]           cy;
    } cfg_t;

    // per-item data that rides alongside the math
    typedef struct packed {
        logic [DW-1:0] pu;
        logic [DW-1:0] pv;
        logic          bad;
    } side_t;

    // one result row
    typedef struct packed {
        logic [2:0][DW-1:0] point;
        logic [5:0][DW-1:0] pose;
        logic [DW-1:0]      residual;
    } row_t;

    function automatic q_t sat_wide(input prod_t v);
        prod_t hi;
        prod_t lo;
        hi = prod_t'(QMAX);
        lo = prod_t'(QMIN);
        if (v > hi)
            sat_wide = QMAX;
        else if (v < lo)
            sat_wide = QMIN;
        else
            sat_wide = v[DW-1:0];
    endfunction

    function automatic prod_t mul_full(input q_t a, input q_t b);
        mul_full = prod_t'(a) * prod_t'(b);
    endfunction

    // scale a product down, truncating toward zero, and saturate
    function automatic q_t mul_fix(input prod_t p, input int unsigned s);
        prod_t bias;
        prod_t q;
        bias = p[PW-1] ? ((prod_t'(1) <<< s) - prod_t'(1)) : '0;
        q = (p + bias) >>> s;
        mul_fix = sat_wide(q);
    endfunction

    function automatic q_t add_sat(input q_t a, input q_t b);
        add_sat = sat_wide(prod_t'(a) + prod_t'(b));
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        sub_sat = sat_wide(prod_t'(a) - prod_t'(b));
    endfunction

    function automatic q_t neg_sat(input q_t a);
        neg_sat = sat_wide(-prod_t'(a));
    endfunction

    function automatic q_t neg_sub_sat(input q_t a, input q_t b);
        neg_sub_sat = sat_wide(-prod_t'(a) - prod_t'(b));
    endfunction

    function automatic q_t sum4_sat(input q_t a, input q_t b, input q_t c, input q_t d);
        sum4_sat = sat_wide(prod_t'(a) + prod_t'(b) + prod_t'(c) + prod_t'(d));
    endfunction

endpackage

`default_nettype wire

/* hdl/rej_xform.sv */
// ---------------------------------------------------------------------------
// rej_xform
// Rigid transform of the world point into camera coordinates, three stages.
// ---------------------------------------------------------------------------
`default_nettype none

module rej_xform
    import rej_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] px,
    input  wire logic [DW-1:0] py,
    input  wire logic [DW-1:0] pz,
    input  wire logic [DW-1:0] pu,
    input  wire logic [DW-1:0] pv,
    input  wire cfg_t          cfg,
    output logic               out_valid,
    output logic [DW-1:0]      cam_x,
    output logic [DW-1:0]      cam_y,
    output logic [DW-1:0]      cam_z,
    output side_t              side
);

    logic [DW-1:0] pt [3];

    logic  a_valid_reg;
    prod_t a_prod_reg [3][3];
    prod_t a_prod_next [3][3];
    side_t a_side_reg;

    logic  b_valid_reg;
    q_t    b_term_reg [3][3];
    q_t    b_term_next [3][3];
    side_t b_side_reg;

    logic  c_valid_reg;
    q_t    c_reg [3];
    q_t    c_next [3];
    q_t    c_sum [3];
    side_t c_side_reg;
    side_t c_side_next;

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    // rotate: nine products, then scale, then sum with translation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a_prod_next[i][j] = mul_full(cfg.r[i][j], pt[j]);
                b_term_next[i][j] = mul_fix(a_prod_reg[i][j], RF);
            end
            c_sum[i] = sum4_sat(b_term_reg[i][0], b_term_reg[i][1], b_term_reg[i][2],
                                cfg.t[i]);
        end
    end

    // flag a non-positive depth and replace it by one LSB
    always_comb
    begin
        c_side_next     = b_side_reg;
        c_side_next.bad = (c_sum[2] <= q_t'(0));
        c_next[0]       = c_sum[0];
        c_next[1]       = c_sum[1];
        c_next[2]       = c_side_next.bad ? q_t'(1) : c_sum[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            a_side_reg <= '{pu: pu, pv: pv, bad: 1'b0};
            b_term_reg <= b_term_next;
            b_side_reg <= a_side_reg;
            c_reg      <= c_next;
            c_side_reg <= c_side_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign cam_x     = c_reg[0];
    assign cam_y     = c_reg[1];
    assign cam_z     = c_reg[2];
    assign side      = c_side_reg;

endmodule

`default_nettype wire

/* hdl/rej_div.sv */
// ---------------------------------------------------------------------------
// rej_div
// Pipelined restoring divider, three lanes: X/Z, Y/Z and 1/Z in Q format.
// ---------------------------------------------------------------------------
`default_nettype none

module rej_div
    import rej_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] cam_x,
    input  wire logic [DW-1:0] cam_y,
    input  wire logic [DW-1:0] cam_z,
    input  wire side_t         in_side,
    output logic               out_valid,
    output logic [DW-1:0]      x,
    output logic [DW-1:0]      y,
    output logic [DW-1:0]      zi,
    output side_t              out_side
);

    localparam int NS = DSTG + 1;

    logic          valid_reg [NS];
    side_t         side_reg  [NS];
    side_t         side_next [NS];
    logic [DW-1:0] den_reg   [NS];
    logic [DW-1:0] den_next  [NS];
    logic [NW-1:0] num_reg   [NS][3];
    logic [NW-1:0] num_next  [NS][3];
    logic [DW-1:0] rem_reg   [NS][3];
    logic [DW-1:0] rem_next  [NS][3];
    logic [QB-1:0] quo_reg   [NS][3];
    logic [QB-1:0] quo_next  [NS][3];
    logic          neg_reg   [NS][3];
    logic          neg_next  [NS][3];
    logic          sat_reg   [NS][3];
    logic          sat_next  [NS][3];

    logic          o_valid_reg;
    side_t         o_side_reg;
    q_t            o_res_reg  [3];
    q_t            o_res_next [3];

    q_t            numer [2];
    logic [DW-1:0] numer_abs [2];

    assign numer[0] = cam_x;
    assign numer[1] = cam_y;

    // prepare magnitudes, saturation test and first partial remainder,
    // then DSTEP quotient bits per stage, most significant first
    always_comb
    begin
        logic [DW:0] trial;
        int          s;
        trial = '0;
        s = 0;

        side_next[0] = in_side;
        den_next[0]  = cam_z;
        for (int l = 0; l < 2; l++)
        begin
            numer_abs[l]   = numer[l][DW-1] ? (~numer[l] + DW'(1)) : numer[l];
            num_next[0][l] = NW'(numer_abs[l]) << FB;
            neg_next[0][l] = numer[l][DW-1];
        end
        num_next[0][2] = NW'(1) << (2 * FB);
        neg_next[0][2] = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            sat_next[0][l] = (num_next[0][l] >= (NW'(cam_z) << (DW - 1)));
            rem_next[0][l] = num_next[0][l][NW-2:DW-1];
            quo_next[0][l] = '0;
        end

        for (int k = 1; k < NS; k++)
        begin
            side_next[k] = side_reg[k-1];
            den_next[k]  = den_reg[k-1];
            for (int l = 0; l < 3; l++)
            begin
                num_next[k][l] = num_reg[k-1][l];
                neg_next[k][l] = neg_reg[k-1][l];
                sat_next[k][l] = sat_reg[k-1][l];
                rem_next[k][l] = rem_reg[k-1][l];
                quo_next[k][l] = quo_reg[k-1][l];
                for (int j = 0; j < DSTEP; j++)
                begin
                    s = (k - 1) * DSTEP + j;
                    if (s < QB)
                    begin
                        trial = {rem_next[k][l], num_reg[k-1][l][NIW'(QB - 1 - s)]};
                        if (trial >= {1'b0, den_reg[k-1]})
                        begin
                            trial          = trial - {1'b0, den_reg[k-1]};
                            quo_next[k][l] = {quo_next[k][l][QB-2:0], 1'b1};
                        end
                        else
                        begin
                            quo_next[k][l] = {quo_next[k][l][QB-2:0], 1'b0};
                        end
                        rem_next[k][l] = trial[DW-1:0];
                    end
                end
            end
        end
    end

    // apply sign and saturation
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (sat_reg[NS-1][l])
                o_res_next[l] = neg_reg[NS-1][l] ? QMIN : QMAX;
            else if (neg_reg[NS-1][l])
                o_res_next[l] = -q_t'({1'b0, quo_reg[NS-1][l]});
            else
                o_res_next[l] = q_t'({1'b0, quo_reg[NS-1][l]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                valid_reg[k] <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                valid_reg[k] <= valid_reg[k-1];
            o_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= side_next;
            den_reg    <= den_next;
            num_reg    <= num_next;
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
            neg_reg    <= neg_next;
            sat_reg    <= sat_next;
            o_res_reg  <= o_res_next;
            o_side_reg <= side_reg[NS-1];
        end
    end

    assign out_valid = o_valid_reg;
    assign x         = o_res_reg[0];
    assign y         = o_res_reg[1];
    assign zi        = o_res_reg[2];
    assign out_side  = o_side_reg;

endmodule

`default_nettype wire

/* hdl/rej_jac.sv */
// ---------------------------------------------------------------------------
// rej_jac
// Projection, residuals, pose Jacobian and point Jacobian, eight stages.
// ---------------------------------------------------------------------------
`default_nettype none

module rej_jac
    import rej_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] x,
    input  wire logic [DW-1:0] y,
    input  wire logic [DW-1:0] zi,
    input  wire side_t         in_side,
    input  wire cfg_t          cfg,
    output logic               out_valid,
    output row_t               u_row,
    output row_t               v_row,
    output logic               bad
);

    logic [7:0] valid_reg;
    side_t      side_reg [8];

    // stage 1: focal products
    prod_t p1_reg [6];
    q_t    x1_reg, y1_reg, zi1_reg;
    // stage 2: scaled focal products
    q_t    fxx2_reg, fyy2_reg, fyx2_reg, fxzi2_reg, fyzi2_reg, fxy2_reg;
    q_t    x2_reg, y2_reg, zi2_reg;
    // stage 3: second products and projection
    prod_t p3_reg [6];
    q_t    proj_u3_reg, proj_v3_reg, fxzi3_reg, fyzi3_reg, fxy3_reg, fyx3_reg;
    // stage 4: scaled second products and residuals
    q_t    s4_reg [6];
    q_t    res_u4_reg, res_v4_reg, fxzi4_reg, fyzi4_reg, fxy4_reg, fyx4_reg;
    // stage 5: pose rows
    q_t    ju5_reg [6];
    q_t    jv5_reg [6];
    q_t    res_u5_reg, res_v5_reg;
    // stage 6: point products, two per term
    prod_t pp6_reg [2][3][2];
    prod_t pp6_next [2][3][2];
    q_t    ju6_reg [6];
    q_t    jv6_reg [6];
    q_t    res_u6_reg, res_v6_reg;
    // stage 7: scaled point products
    q_t    pf7_reg [2][3][2];
    q_t    pf7_next [2][3][2];
    q_t    ju7_reg [6];
    q_t    jv7_reg [6];
    q_t    res_u7_reg, res_v7_reg;
    // stage 8: finished rows
    row_t  u8_reg, v8_reg;
    row_t  u8_next, v8_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pp6_next[0][k][0] = mul_full(ju5_reg[0], cfg.r[0][k]);
            pp6_next[0][k][1] = mul_full(ju5_reg[2], cfg.r[2][k]);
            pp6_next[1][k][0] = mul_full(jv5_reg[1], cfg.r[1][k]);
            pp6_next[1][k][1] = mul_full(jv5_reg[2], cfg.r[2][k]);
            for (int r = 0; r < 2; r++)
            begin
                pf7_next[r][k][0] = mul_fix(pp6_reg[r][k][0], RF);
                pf7_next[r][k][1] = mul_fix(pp6_reg[r][k][1], RF);
            end
        end
    end

    // pack the rows with point terms summed
    always_comb
    begin
        u8_next.residual = res_u7_reg;
        v8_next.residual = res_v7_reg;
        for (int i = 0; i < 6; i++)
        begin
            u8_next.pose[i] = ju7_reg[i];
            v8_next.pose[i] = jv7_reg[i];
        end
        for (int k = 0; k < 3; k++)
        begin
            u8_next.point[k] = add_sat(pf7_reg[0][k][0], pf7_reg[0][k][1]);
            v8_next.point[k] = add_sat(pf7_reg[1][k][0], pf7_reg[1][k][1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[6:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < 8; k++)
                side_reg[k] <= side_reg[k-1];

            // focal products
            p1_reg[0] <= mul_full(cfg.fx, x);
            p1_reg[1] <= mul_full(cfg.fy, y);
            p1_reg[2] <= mul_full(cfg.fy, x);
            p1_reg[3] <= mul_full(cfg.fx, zi);
            p1_reg[4] <= mul_full(cfg.fy, zi);
            p1_reg[5] <= mul_full(cfg.fx, y);
            x1_reg    <= x;
            y1_reg    <= y;
            zi1_reg   <= zi;

            // scale focal products
            fxx2_reg  <= mul_fix(p1_reg[0], FB);
            fyy2_reg  <= mul_fix(p1_reg[1], FB);
            fyx2_reg  <= mul_fix(p1_reg[2], FB);
            fxzi2_reg <= mul_fix(p1_reg[3], FB);
            fyzi2_reg <= mul_fix(p1_reg[4], FB);
            fxy2_reg  <= mul_fix(p1_reg[5], FB);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            zi2_reg   <= zi1_reg;

            // second products and projected pixel
            p3_reg[0]   <= mul_full(fxx2_reg, zi2_reg);
            p3_reg[1]   <= mul_full(fxx2_reg, y2_reg);
            p3_reg[2]   <= mul_full(fxx2_reg, x2_reg);
            p3_reg[3]   <= mul_full(fyy2_reg, zi2_reg);
            p3_reg[4]   <= mul_full(fyy2_reg, y2_reg);
            p3_reg[5]   <= mul_full(fyy2_reg, x2_reg);
            proj_u3_reg <= add_sat(fxx2_reg, cfg.cx);
            proj_v3_reg <= add_sat(fyy2_reg, cfg.cy);
            fxzi3_reg   <= fxzi2_reg;
            fyzi3_reg   <= fyzi2_reg;
            fxy3_reg    <= fxy2_reg;
            fyx3_reg    <= fyx2_reg;

            // scale and form residuals
            for (int i = 0; i < 6; i++)
                s4_reg[i] <= mul_fix(p3_reg[i], FB);
            res_u4_reg <= sub_sat(side_reg[2].pu, proj_u3_reg);
            res_v4_reg <= sub_sat(side_reg[2].pv, proj_v3_reg);
            fxzi4_reg  <= fxzi3_reg;
            fyzi4_reg  <= fyzi3_reg;
            fxy4_reg   <= fxy3_reg;
            fyx4_reg   <= fyx3_reg;

            // pose rows
            ju5_reg[0] <= neg_sat(fxzi4_reg);
            ju5_reg[1] <= '0;
            ju5_reg[2] <= s4_reg[0];
            ju5_reg[3] <= s4_reg[1];
            ju5_reg[4] <= neg_sub_sat(cfg.fx, s4_reg[2]);
            ju5_reg[5] <= fxy4_reg;
            jv5_reg[0] <= '0;
            jv5_reg[1] <= neg_sat(fyzi4_reg);
            jv5_reg[2] <= s4_reg[3];
            jv5_reg[3] <= add_sat(cfg.fy, s4_reg[4]);
            jv5_reg[4] <= neg_sat(s4_reg[5]);
            jv5_reg[5] <= neg_sat(fyx4_reg);
            res_u5_reg <= res_u4_reg;
            res_v5_reg <= res_v4_reg;

            // point products
            pp6_reg    <= pp6_next;
            ju6_reg    <= ju5_reg;
            jv6_reg    <= jv5_reg;
            res_u6_reg <= res_u5_reg;
            res_v6_reg <= res_v5_reg;

            // scale point products
            pf7_reg    <= pf7_next;
            ju7_reg    <= ju6_reg;
            jv7_reg    <= jv6_reg;
            res_u7_reg <= res_u6_reg;
            res_v7_reg <= res_v6_reg;

            u8_reg <= u8_next;
            v8_reg <= v8_next;
        end
    end

    assign out_valid = valid_reg[7];
    assign u_row     = u8_reg;
    assign v_row     = v8_reg;
    assign bad       = side_reg[7].bad;

endmodule

`default_nettype wire

/* hdl/reprojection_error_jacobian.sv */
// ---------------------------------------------------------------------------
// reprojection_error_jacobian
// Pinhole reprojection residual with pose and point Jacobians, pipelined.
// ---------------------------------------------------------------------------
//  channel   direction  width  content
//  s_*       in         160    point_x, point_y, point_z, pixel_u, pixel_v
//  m_*       out        320    residual, jac_pose_0..5, jac_point_0..2
//                              tlast = last_row, tuser = depth_bad
//  apb       in/out     64     eight 64-bit registers at 8*i
//
//  The output port delivers each item's two rows, u then v, one per cycle while
//  m_tready is high; no input is taken while a u row waits. Path: transform,
//  divider (31 quotient bits, 4 per stage), Jacobian, output buffer.
//  Reset clears all valid bits and loads the register reset values.
//  A stall on m_tready freezes the whole pipeline; s_tready follows it.
// ---------------------------------------------------------------------------
`default_nettype none

module reprojection_error_jacobian
    import rej_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // slave stream: point_x, point_y, point_z, pixel_u, pixel_v (low first)
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [159:0]  s_tdata,
    // master stream: residual, jac_pose_0..5, jac_point_0..2 (low first)
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [319:0]       m_tdata,
    output logic               m_tlast,
    // depth_bad
    output logic [0:0]         m_tuser,
    // configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [AW-1:0] paddr,
    input  wire logic [CW-1:0] pwdata,
    output logic [CW-1:0]      prdata,
    output logic               pready
);

    logic [CW-1:0] cfg_reg [NREG];
    logic [RIW-1:0] reg_idx;
    cfg_t          cfg;

    logic          en;
    logic          xf_valid;
    logic [DW-1:0] cam_x, cam_y, cam_z;
    side_t         xf_side;
    logic          dv_valid;
    logic [DW-1:0] dv_x, dv_y, dv_zi;
    side_t         dv_side;
    logic          jc_valid;
    row_t          jc_u, jc_v;
    logic          jc_bad;

    logic          obuf_valid_reg;
    logic          row_reg;
    row_t          u_row_reg, v_row_reg;
    logic          bad_reg;

    // register file
    assign reg_idx = paddr[AW-1:3];
    assign pready  = 1'b1;
    assign prdata  = cfg_reg[reg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                cfg_reg[i] <= REG_RESET[i];
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[reg_idx] <= pwdata;
        end
    end

    // decode pose and camera
    always_comb
    begin
        cfg.r[0][0] = cfg_reg[REG_ROT_00_01][31:0];
        cfg.r[0][1] = cfg_reg[REG_ROT_00_01][63:32];
        cfg.r[0][2] = cfg_reg[REG_ROT_02_10][31:0];
        cfg.r[1][0] = cfg_reg[REG_ROT_02_10][63:32];
        cfg.r[1][1] = cfg_reg[REG_ROT_11_12][31:0];
        cfg.r[1][2] = cfg_reg[REG_ROT_11_12][63:32];
        cfg.r[2][0] = cfg_reg[REG_ROT_20_21][31:0];
        cfg.r[2][1] = cfg_reg[REG_ROT_20_21][63:32];
        cfg.r[2][2] = cfg_reg[REG_ROT_22_TRANS_X][31:0];
        cfg.t[0]    = cfg_reg[REG_ROT_22_TRANS_X][63:32];
        cfg.t[1]    = cfg_reg[REG_TRANS_Y_Z][31:0];
        cfg.t[2]    = cfg_reg[REG_TRANS_Y_Z][63:32];
        cfg.fx      = cfg_reg[REG_FOCAL_XY][31:0];
        cfg.fy      = cfg_reg[REG_FOCAL_XY][63:32];
        cfg.cx      = cfg_reg[REG_CENTER_XY][31:0];
        cfg.cy      = cfg_reg[REG_CENTER_XY][63:32];
    end

    // advance when the output buffer is empty or hands off its last row
    assign en       = !obuf_valid_reg || (row_reg && m_tready);
    assign s_tready = en;

    rej_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .px        (s_tdata[31:0]),
        .py        (s_tdata[63:32]),
        .pz        (s_tdata[95:64]),
        .pu        (s_tdata[127:96]),
        .pv        (s_tdata[159:128]),
        .cfg       (cfg),
        .out_valid (xf_valid),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z),
        .side      (xf_side)
    );

    rej_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z),
        .in_side   (xf_side),
        .out_valid (dv_valid),
        .x         (dv_x),
        .y         (dv_y),
        .zi        (dv_zi),
        .out_side  (dv_side)
    );

    rej_jac u_jac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .x         (dv_x),
        .y         (dv_y),
        .zi        (dv_zi),
        .in_side   (dv_side),
        .cfg       (cfg),
        .out_valid (jc_valid),
        .u_row     (jc_u),
        .v_row     (jc_v),
        .bad       (jc_bad)
    );

    // output buffer: hold one item, send u row then v row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_valid_reg <= 1'b0;
            row_reg        <= 1'b0;
        end
        else if (en)
        begin
            obuf_valid_reg <= jc_valid;
            row_reg        <= 1'b0;
        end
        else if (m_tready)
        begin
            row_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_row_reg <= jc_u;
            v_row_reg <= jc_v;
            bad_reg   <= jc_bad;
        end
    end

    assign m_tvalid   = obuf_valid_reg;
    assign m_tdata    = row_reg ? v_row_reg : u_row_reg;
    assign m_tlast    = row_reg;
    assign m_tuser[0] = bad_reg;

endmodule

`default_nettype wire

/* hdl/rej_checker.sv */
// ---------------------------------------------------------------------------
// rej_checker
// Port-level checks on row order and input throttling, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "reprojection_error_jacobian_defines.svh"

module rej_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    // an offered word stays offered
    `REJ_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // the u row is always followed by its v row
    `REJ_ASSERT_NEXT(a_v_follows_u, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)

    // both rows of an item carry the same depth flag
    `REJ_ASSERT_NEXT(a_flag_same, clk, rst_n, m_tvalid && m_tready && !m_tlast, $stable(m_tuser))

    // no new input while a u row is still pending
    `REJ_ASSERT_NOW(a_throttle, clk, rst_n, m_tvalid && !m_tlast, !s_tready)

endmodule

bind reprojection_error_jacobian rej_checker u_rej_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/reprojection_error_jacobian_test.sv */
// ---------------------------------------------------------------------------
// reprojection_error_jacobian_test
// Streams world points and measured pixels through the reprojection block
// under several pose and camera settings. Predicts both result rows of each
// point in fixed point and compares every field of every result word.
// ---------------------------------------------------------------------------
`default_nettype none

module reprojection_error_jacobian_test;
    import rej_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES   = 30;

    // one result row as seen on the master stream
    typedef struct {
        logic [319:0] data;
        bit           last;
        bit           bad;
    } exp_row_t;

    // -----------------------------------------------------------------------
    // Reprojection scoreboard: own copy of the registers, predictor, checks
    // -----------------------------------------------------------------------
    class reproj_checker;
        logic [63:0] regs [NREG];
        exp_row_t    pending_rows [$];
        int          mismatches;
        int          rows_checked;
        int          points_noted;
        int          bad_depths;

        function new();
            for (int i = 0; i < NREG; i++)
                regs[i] = REG_RESET[i];
        endfunction

        function void set_reg(int idx, logic [63:0] val);
            if (idx < NREG)
                regs[idx] = val;
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endfunction

        // signed word of a register, low or high half
        function longint word_of(int idx, bit hi);
            logic [31:0] w;
            w = hi ? regs[idx][63:32] : regs[idx][31:0];
            return longint'($signed(w));
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // magnitude with sign back to a saturated value
        function longint clip_mag(logic [127:0] m, bit neg);
            logic [127:0] cap;
            cap = 128'd1 << 31;
            if (m > cap)
                m = cap;
            if (neg)
                return -longint'(m[63:0]);
            return (m == cap) ? longint'(cap[63:0]) - 1 : longint'(m[63:0]);
        endfunction

        // a*b/2^s, truncated toward zero
        function longint scale_mul(longint a, longint b, int s);
            logic [127:0] ua;
            logic [127:0] ub;
            ua = (a < 0) ? 128'(-a) : 128'(a);
            ub = (b < 0) ? 128'(-b) : 128'(b);
            return clip_mag((ua * ub) >> s, (a < 0) != (b < 0));
        endfunction

        // a*2^s/d, truncated toward zero
        function longint scale_div(longint a, longint d, int s);
            logic [127:0] ua;
            logic [127:0] ud;
            ua = (a < 0) ? 128'(-a) : 128'(a);
            ud = (d < 0) ? 128'(-d) : 128'(d);
            if (ud == 0)
                ud = 1;
            return clip_mag((ua << s) / ud, (a < 0) != (d < 0));
        endfunction

        // compute both rows for one point and queue them
        function void note_item(logic [159:0] word);
            longint r [3][3];
            longint t [3];
            longint p [3];
            longint c [3];
            longint jr [2][6];
            longint res [2];
            longint fx, fy, cx, cy, x, y, zi, fxx, fyy, fyx, acc;
            bit bad;
            exp_row_t row;

            r[0][0] = word_of(REG_ROT_00_01, 0);      r[0][1] = word_of(REG_ROT_00_01, 1);
            r[0][2] = word_of(REG_ROT_02_10, 0);      r[1][0] = word_of(REG_ROT_02_10, 1);
            r[1][1] = word_of(REG_ROT_11_12, 0);      r[1][2] = word_of(REG_ROT_11_12, 1);
            r[2][0] = word_of(REG_ROT_20_21, 0);      r[2][1] = word_of(REG_ROT_20_21, 1);
            r[2][2] = word_of(REG_ROT_22_TRANS_X, 0); t[0]    = word_of(REG_ROT_22_TRANS_X, 1);
            t[1]    = word_of(REG_TRANS_Y_Z, 0);      t[2]    = word_of(REG_TRANS_Y_Z, 1);
            fx = word_of(REG_FOCAL_XY, 0);  fy = word_of(REG_FOCAL_XY, 1);
            cx = word_of(REG_CENTER_XY, 0); cy = word_of(REG_CENTER_XY, 1);
            for (int i = 0; i < 3; i++)
                p[i] = longint'($signed(word[32*i +: 32]));

            // rigid transform into the camera frame
            for (int i = 0; i < 3; i++)
                c[i] = sat32(scale_mul(r[i][0], p[0], RF) + scale_mul(r[i][1], p[1], RF)
                             + scale_mul(r[i][2], p[2], RF) + t[i]);
            bad = (c[2] <= 0);
            if (bad)
                c[2] = 1;
            bad_depths += bad;

            // projection
            x   = scale_div(c[0], c[2], FB);
            y   = scale_div(c[1], c[2], FB);
            zi  = scale_div(1, c[2], 2 * FB);
            fxx = scale_mul(fx, x, FB);
            fyy = scale_mul(fy, y, FB);
            fyx = scale_mul(fy, x, FB);
            res[0] = sat32(longint'($signed(word[96 +: 32])) - sat32(fxx + cx));
            res[1] = sat32(longint'($signed(word[128 +: 32])) - sat32(fyy + cy));

            // pose Jacobian rows
            jr[0][0] = sat32(-scale_mul(fx, zi, FB));
            jr[0][1] = 0;
            jr[0][2] = scale_mul(fxx, zi, FB);
            jr[0][3] = scale_mul(fxx, y, FB);
            jr[0][4] = sat32(-fx - scale_mul(fxx, x, FB));
            jr[0][5] = scale_mul(fx, y, FB);
            jr[1][0] = 0;
            jr[1][1] = sat32(-scale_mul(fy, zi, FB));
            jr[1][2] = scale_mul(fyy, zi, FB);
            jr[1][3] = sat32(fy + scale_mul(fyy, y, FB));
            jr[1][4] = sat32(-scale_mul(fyy, x, FB));
            jr[1][5] = sat32(-fyx);

            // pack rows, point terms are the first three pose terms times R
            for (int rw = 0; rw < 2; rw++)
            begin
                row.data[31:0] = 32'(res[rw]);
                for (int i = 0; i < 6; i++)
                    row.data[32*(1+i) +: 32] = 32'(jr[rw][i]);
                for (int k = 0; k < 3; k++)
                begin
                    acc = sat32(scale_mul(jr[rw][0], r[0][k], RF)
                                + scale_mul(jr[rw][1], r[1][k], RF)
                                + scale_mul(jr[rw][2], r[2][k], RF));
                    row.data[32*(7+k) +: 32] = 32'(acc);
                end
                row.last = (rw == 1);
                row.bad  = bad;
                pending_rows.insert(pending_rows.size(), row);
            end
            points_noted++;
        endfunction

        function void check_row(logic [319:0] data, logic last, logic bad);
            exp_row_t want;
            if (pending_rows.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (data[31:0] !== want.data[31:0])
                report($sformatf("residual got %h want %h", data[31:0], want.data[31:0]));
            for (int i = 0; i < 6; i++)
                if (data[32*(1+i) +: 32] !== want.data[32*(1+i) +: 32])
                    report($sformatf("jac_pose_%0d got %h want %h", i,
                                     data[32*(1+i) +: 32], want.data[32*(1+i) +: 32]));
            for (int k = 0; k < 3; k++)
                if (data[32*(7+k) +: 32] !== want.data[32*(7+k) +: 32])
                    report($sformatf("jac_point_%0d got %h want %h", k,
                                     data[32*(7+k) +: 32], want.data[32*(7+k) +: 32]));
            if (last !== want.last)
                report($sformatf("last_row got %b want %b", last, want.last));
            if (bad !== want.bad)
                report($sformatf("depth_bad got %b want %b", bad, want.bad));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Block signals
    // -----------------------------------------------------------------------
    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [159:0]  s_tdata;     // point_x, point_y, point_z, pixel_u, pixel_v
    logic          m_tvalid;
    logic          m_tready;
    logic [319:0]  m_tdata;     // residual, jac_pose_0..5, jac_point_0..2
    logic          m_tlast;
    logic [0:0]    m_tuser;     // depth_bad
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [CW-1:0] pwdata;
    logic [CW-1:0] prdata;
    logic          pready;

    reproj_checker checker_h;
    bit  calm;
    int  holdoff_left;
    int  idle_cycles;
    int  config_writes;

    reprojection_error_jacobian u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // note inputs, check results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
                checker_h.note_item(s_tdata);
            if (m_tvalid && m_tready)
                checker_h.check_row(m_tdata, m_tlast, m_tuser[0]);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d rows outstanding",
                         checker_h.pending_rows.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                m_tready <= 1'b0;
                holdoff_left--;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // write one register over the configuration port
    task automatic write_reg(int idx, logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 8);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        checker_h.set_reg(idx, val);
        config_writes++;
    endtask

    // offer one point, with an occasional gap before it
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] pu, logic [31:0] pv);
        if (!calm && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pv, pu, pz, py, px};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // drop valid and wait until every row has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (checker_h.pending_rows.size() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] q16(int v);
        return 32'(v) << 16;
    endfunction

    // plausible rotation word in [-1.0, 1.0] Q2.30
    function automatic logic [31:0] rot_word();
        return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
    endfunction

    // load one of the pose and camera settings
    task automatic load_setting(int phase);
        logic [31:0] w [16];
        case (phase)
            1: for (int i = 0; i < 16; i++) w[i] = 32'h0;
            2: for (int i = 0; i < 16; i++) w[i] = 32'hFFFF_FFFF;
            3: for (int i = 0; i < 16; i++) w[i] = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            7: for (int i = 0; i < 16; i++) w[i] = $urandom;
            default:
            begin
                for (int i = 0; i < 9; i++)
                    w[i] = rot_word();
                w[9]  = q16($urandom_range(200)) - q16(100);
                w[10] = q16($urandom_range(200)) - q16(100);
                w[11] = q16($urandom_range(50, 5));
                w[12] = q16($urandom_range(1000, 100));
                w[13] = q16($urandom_range(1000, 100));
                w[14] = q16($urandom_range(640));
                w[15] = q16($urandom_range(480));
            end
        endcase
        for (int i = 0; i < NREG; i++)
            write_reg(i, {w[2*i+1], w[2*i]});
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [31:0] px, py, pz, pu, pv;
        checker_h    = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        holdoff_left = 0;
        idle_cycles  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a few points at reset values: focal zero, identity pose
        send_point(q16(1), q16(2), q16(3), q16(4), q16(5));
        send_point(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        // directed: identity pose at depth 5, focal 500, center (320, 240)
        write_reg(REG_ROT_00_01, 64'h0000_0000_4000_0000);
        write_reg(REG_ROT_02_10, 64'h0);
        write_reg(REG_ROT_11_12, 64'h0000_0000_4000_0000);
        write_reg(REG_ROT_20_21, 64'h0);
        write_reg(REG_ROT_22_TRANS_X, 64'h0000_0000_4000_0000);
        write_reg(REG_TRANS_Y_Z, {q16(5), 32'h0});
        write_reg(REG_FOCAL_XY, {q16(500), q16(500)});
        write_reg(REG_CENTER_XY, {q16(240), q16(320)});
        send_point(32'h0, 32'h0, 32'h0, q16(320), q16(240));
        send_point(q16(1), q16(2), q16(3), q16(400), q16(300));
        send_point(q16(-1), q16(-2), q16(7), q16(-10), q16(10));
        // camera depth exactly zero, then negative
        send_point(q16(1), q16(1), q16(-5), q16(0), q16(0));
        send_point(q16(2), q16(-3), q16(-50), q16(100), q16(100));
        // field extremes and saturation
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, q16(-4) - 32'd65535, 32'h0, 32'hFFFF_FFFF);
        send_point(q16(30000), q16(-30000), q16(1), 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333, 32'hF0F0_F0F0);
        drain();

        // random phases over several settings
        for (int ph = 1; ph <= PHASES; ph++)
        begin
            load_setting(ph);
            calm = (ph == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 4 && n == 20)
                    holdoff_left = HOLDOFF_CYCLES;
                if (ph == 6 && n == 45)
                    drain();
                if ($urandom_range(99) < 75)
                begin
                    // well-formed: modest point and pixel values
                    px = q16($urandom_range(40)) - q16(20) + 32'($urandom_range(65535));
                    py = q16($urandom_range(40)) - q16(20) + 32'($urandom_range(65535));
                    pz = q16($urandom_range(10)) - q16(5) + 32'($urandom_range(65535));
                    pu = q16($urandom_range(2000)) - q16(1000) + 32'($urandom_range(65535));
                    pv = q16($urandom_range(2000)) - q16(1000) + 32'($urandom_range(65535));
                end
                else
                begin
                    px = $urandom;
                    py = $urandom;
                    pz = $urandom;
                    pu = $urandom;
                    pv = $urandom;
                end
                send_point(px, py, pz, pu, pv);
            end
            drain();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d points, %0d rows checked, %0d with bad depth",
                 checker_h.points_noted, checker_h.rows_checked, checker_h.bad_depths);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 config_writes, PHASES + 1, checker_h.mismatches);
        if (checker_h.mismatches == 0 && checker_h.pending_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
